### rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed: %m");

// Property checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed: %m");

`endif

### rtl/imufp_pkg.sv
// Types and constants of the inertial sensor serial frame parser.
package imufp_pkg;

    localparam logic [7:0] HDR_BYTE   = 8'h55;
    localparam logic [7:0] TYPE_ACC   = 8'h51;
    localparam logic [7:0] TYPE_GYRO  = 8'h52;
    localparam logic [7:0] TYPE_ANGLE = 8'h53;

    localparam int FRAME_LEN  = 11;
    localparam int DATA_BYTES = FRAME_LEN - 2;
    localparam int COUNT_W    = $clog2(FRAME_LEN);

    localparam logic [COUNT_W-1:0] COUNT_IDLE = '0;
    localparam logic [COUNT_W-1:0] COUNT_LAST = COUNT_W'(FRAME_LEN - 1);

    localparam logic [15:0] ANGLE_OFFS = 16'h8000;

    typedef enum logic [1:0] {
        KIND_ACC     = 2'd0,
        KIND_GYRO    = 2'd1,
        KIND_ANGLE   = 2'd2,
        KIND_UNKNOWN = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0]         type_byte;
        logic signed [15:0] word_x;
        logic signed [15:0] word_y;
        logic signed [15:0] word_z;
        logic signed [15:0] word_t;
    } t_frame;

endpackage

### rtl/imufp_assembler.sv
// Header search, byte counter and shift line that collect one frame.
module imufp_assembler (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    input  logic [7:0]            i_byte,
    output logic                  o_last,
    output imufp_pkg::t_frame     o_frame
);

    logic [imufp_pkg::COUNT_W-1:0] r_count;
    logic [imufp_pkg::COUNT_W-1:0] n_count;
    logic [7:0]                    r_bytes [imufp_pkg::DATA_BYTES];
    logic                          w_store;

    assign o_last  = (r_count >= imufp_pkg::COUNT_LAST);
    assign w_store = i_take && (r_count != imufp_pkg::COUNT_IDLE) && !o_last;

    always_comb begin
        n_count = r_count;
        if (i_take) begin
            if (r_count == imufp_pkg::COUNT_IDLE) begin
                if (i_byte == imufp_pkg::HDR_BYTE) begin
                    n_count = imufp_pkg::COUNT_W'(1);
                end
            end else if (o_last) begin
                n_count = imufp_pkg::COUNT_IDLE;
            end else begin
                n_count = r_count + imufp_pkg::COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= imufp_pkg::COUNT_IDLE;
        end else begin
            r_count <= n_count;
        end
    end

    // The newest byte enters at the top, so a full line holds frame bytes 1 to 9 in order.
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            for (int i = 0; i < imufp_pkg::DATA_BYTES - 1; i++) begin
                r_bytes[i] <= r_bytes[i+1];
            end
            r_bytes[imufp_pkg::DATA_BYTES-1] <= i_byte;
        end
    end

    assign o_frame.type_byte = r_bytes[0];
    assign o_frame.word_x    = {r_bytes[2], r_bytes[1]};
    assign o_frame.word_y    = {r_bytes[4], r_bytes[3]};
    assign o_frame.word_z    = {r_bytes[6], r_bytes[5]};
    assign o_frame.word_t    = {r_bytes[8], r_bytes[7]};

endmodule

### rtl/imufp_decoder.sv
// Type decode, angle offset and the result register.
module imufp_decoder (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  imufp_pkg::t_frame     i_frame,
    input  logic                  i_stall,
    output logic                  o_ready,
    output logic                  o_valid,
    output logic [1:0]            o_frame_kind,
    output logic signed [15:0]    o_value_x,
    output logic signed [15:0]    o_value_y,
    output logic signed [15:0]    o_value_z,
    output logic signed [15:0]    o_temperature
);

    imufp_pkg::t_kind   n_kind;
    logic signed [15:0] n_x;
    logic               r_valid;
    imufp_pkg::t_kind   r_kind;
    logic signed [15:0] r_x;
    logic signed [15:0] r_y;
    logic signed [15:0] r_z;
    logic signed [15:0] r_t;

    always_comb begin
        n_x = i_frame.word_x;
        case (i_frame.type_byte)
            imufp_pkg::TYPE_ACC: begin
                n_kind = imufp_pkg::KIND_ACC;
            end
            imufp_pkg::TYPE_GYRO: begin
                n_kind = imufp_pkg::KIND_GYRO;
            end
            imufp_pkg::TYPE_ANGLE: begin
                n_kind = imufp_pkg::KIND_ANGLE;
                n_x    = i_frame.word_x ^ imufp_pkg::ANGLE_OFFS;
            end
            default: begin
                n_kind = imufp_pkg::KIND_UNKNOWN;
            end
        endcase
    end

    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_kind <= n_kind;
            r_x    <= n_x;
            r_y    <= i_frame.word_y;
            r_z    <= i_frame.word_z;
            r_t    <= i_frame.word_t;
        end
    end

    assign o_valid       = r_valid;
    assign o_frame_kind  = r_kind;
    assign o_value_x     = r_x;
    assign o_value_y     = r_y;
    assign o_value_z     = r_z;
    assign o_temperature = r_t;

endmodule

### rtl/imu_serial_frame_parser.sv
// Top level of the inertial sensor serial frame parser.
// The block takes one received serial byte per request and can accept a byte in every cycle
// while o_stall is low. It searches for the header byte 0x55, collects the ten bytes that
// follow, and on the last of them issues one record with the frame kind and the four signed
// words; the checksum byte is not checked. A byte passes through an input register and the
// record through a result register: the final byte of a frame is held in the input register
// and its record is then loaded into the result register, which drives the outputs.
// Bytes that do not finish a frame never wait on the output side, and the final byte of a
// frame waits only while a previous record is still held in the result register.
module imu_serial_frame_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_rx_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_frame_kind,
    output logic signed [15:0] o_value_x,
    output logic signed [15:0] o_value_y,
    output logic signed [15:0] o_value_z,
    output logic signed [15:0] o_temperature
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              w_last;
    logic              w_out_ready;
    logic              w_take;
    logic              w_load_in;
    imufp_pkg::t_frame w_frame;

    assign w_take    = r_in_valid && (!w_last || w_out_ready);
    assign w_load_in = !r_in_valid || w_take;
    assign o_stall   = !w_load_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_load_in) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_in && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    imufp_assembler u_assembler (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_byte  (r_in_byte),
        .o_last  (w_last),
        .o_frame (w_frame)
    );

    imufp_decoder u_decoder (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_take && w_last),
        .i_frame       (w_frame),
        .i_stall       (i_stall),
        .o_ready       (w_out_ready),
        .o_valid       (o_valid),
        .o_frame_kind  (o_frame_kind),
        .o_value_x     (o_value_x),
        .o_value_y     (o_value_y),
        .o_value_z     (o_value_z),
        .o_temperature (o_temperature)
    );

endmodule

### rtl/imufp_checker.sv
// Port-level checker for the serial frame parser and its bind statement.
`include "assert_macros.svh"

module imufp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic [1:0]         o_frame_kind,
    input logic signed [15:0] o_value_x,
    input logic signed [15:0] o_value_y,
    input logic signed [15:0] o_value_z,
    input logic signed [15:0] o_temperature
);

    // A reset leaves no record pending.
    `ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !o_valid)

    // A stalled record keeps its contents.
    `ASSERT_CLK(a_hold_record, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_frame_kind) && $stable(o_value_x) && $stable(o_value_y) && $stable(o_value_z) && $stable(o_temperature))

    // A new record follows an accepted request, the one that finished its frame.
    `ASSERT_CLK(a_record_latency, i_clk, i_rst_n, $rose(o_valid) |-> $past(i_valid && !o_stall, 2))

    // The input is held off only while a finished record waits on a stalled output.
    `ASSERT_CLK(a_stall_cause, i_clk, i_rst_n, o_stall |-> o_valid && i_stall)

endmodule

bind imu_serial_frame_parser imufp_checker u_imufp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_frame_kind  (o_frame_kind),
    .o_value_x     (o_value_x),
    .o_value_y     (o_value_y),
    .o_value_z     (o_value_z),
    .o_temperature (o_temperature)
);
